[sv/vc40_pkg.sv]
// ----------------------------------------------------------------------------
// vc40_pkg
// Shared types, constants and symbol mapping functions of the 40-symbol
// Vigenere cipher core.
// ----------------------------------------------------------------------------
`default_nettype none

package vc40_pkg;

  localparam int unsigned KeyMaxDefault = 32;

  localparam int unsigned SymW        = 6;
  localparam int unsigned KeySyms     = 32;
  localparam int unsigned KeyIdxW     = 5;
  localparam int unsigned KeyWordSyms = 8;
  localparam int unsigned KeyWordW    = KeyWordSyms * SymW;
  localparam int unsigned KeyWords    = KeySyms / KeyWordSyms;
  localparam int unsigned LenW        = 6;
  localparam int unsigned AddrW       = 6;
  localparam int unsigned DataW       = 64;
  localparam int unsigned RegIdxW     = 3;
  localparam int unsigned RegIdxLsb   = 3;

  localparam logic [6:0] SymCount = 7'd40;

  localparam logic [7:0] CharLowA  = 8'd97;
  localparam logic [7:0] CharLowZ  = 8'd122;
  localparam logic [7:0] CharZero  = 8'd48;
  localparam logic [7:0] CharNine  = 8'd57;
  localparam logic [7:0] CharSpace = 8'd32;
  localparam logic [7:0] CharDot   = 8'd46;
  localparam logic [7:0] CharComma = 8'd44;
  localparam logic [7:0] CharApos  = 8'd39;

  localparam logic [SymW-1:0] SymLetters = 6'd26;
  localparam logic [SymW-1:0] SymSpace   = 6'd26;
  localparam logic [SymW-1:0] SymDot     = 6'd27;
  localparam logic [SymW-1:0] SymComma   = 6'd28;
  localparam logic [SymW-1:0] SymApos    = 6'd29;
  localparam logic [SymW-1:0] SymDigit0  = 6'd30;
  localparam logic [SymW-1:0] SymDefault = 6'd0;

  localparam logic [7:0] DigitOffset = CharZero - 8'(SymDigit0);

  typedef enum logic [RegIdxW-1:0] {
    REG_KEY_LENGTH   = 3'd0,
    REG_DECRYPT_MODE = 3'd1,
    REG_KEY_WORD_0   = 3'd2,
    REG_KEY_WORD_1   = 3'd3,
    REG_KEY_WORD_2   = 3'd4,
    REG_KEY_WORD_3   = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       message_end;
  } in_req_t;

  typedef struct packed {
    logic [7:0] cipher_byte;
    logic       end_of_message;
  } out_req_t;

  typedef struct packed {
    logic [LenW-1:0]          key_length;
    logic                     decrypt_mode;
    logic [KeySyms*SymW-1:0]  key_syms;
  } cfg_t;

  typedef struct packed {
    logic [7:0]      text_byte;
    logic            message_end;
    logic [SymW-1:0] key_sym;
  } stage_t;

  function automatic logic [SymW-1:0] byte_to_symbol(input logic [7:0] b);
    logic [SymW-1:0] s;
    if (b >= CharLowA && b <= CharLowZ) begin
      s = SymW'(b - CharLowA);
    end else if (b >= CharZero && b <= CharNine) begin
      s = SymW'(b - DigitOffset);
    end else if (b == CharSpace) begin
      s = SymSpace;
    end else if (b == CharDot) begin
      s = SymDot;
    end else if (b == CharComma) begin
      s = SymComma;
    end else if (b == CharApos) begin
      s = SymApos;
    end else begin
      s = SymDefault;
    end
    return s;
  endfunction

  function automatic logic [7:0] symbol_to_byte(input logic [SymW-1:0] s);
    logic [7:0] b;
    if (s < SymLetters) begin
      b = {2'b00, s} + CharLowA;
    end else if (s == SymSpace) begin
      b = CharSpace;
    end else if (s == SymDot) begin
      b = CharDot;
    end else if (s == SymComma) begin
      b = CharComma;
    end else if (s == SymApos) begin
      b = CharApos;
    end else if ({1'b0, s} < SymCount) begin
      b = {2'b00, s} + DigitOffset;
    end else begin
      b = CharLowA;
    end
    return b;
  endfunction

  function automatic logic [SymW-1:0] mod_shift(input logic [SymW-1:0] s,
                                                input logic [SymW-1:0] k,
                                                input logic            dec);
    logic [6:0] sum;
    if (dec) begin
      sum = {1'b0, s} + SymCount - {1'b0, k};
    end else begin
      sum = {1'b0, s} + {1'b0, k};
    end
    if (sum >= SymCount) begin
      sum = sum - SymCount;
    end
    return SymW'(sum);
  endfunction

endpackage

`default_nettype wire

[sv/vc40_regs.sv]
// ----------------------------------------------------------------------------
// vc40_regs
// APB register file: key length, direction and the four packed key words.
// ----------------------------------------------------------------------------
`default_nettype none

module vc40_regs import vc40_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  logic [LenW-1:0]     key_length_q;
  logic                decrypt_mode_q;
  logic [KeyWordW-1:0] key_word_q [KeyWords];
  logic                wr_en;
  reg_idx_e            reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = reg_idx_e'(paddr[RegIdxLsb +: RegIdxW]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_length_q   <= LenW'(1);
      decrypt_mode_q <= 1'b0;
      for (int i = 0; i < KeyWords; i++) begin
        key_word_q[i] <= '0;
      end
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_KEY_LENGTH:   key_length_q   <= pwdata[LenW-1:0];
        REG_DECRYPT_MODE: decrypt_mode_q <= pwdata[0];
        REG_KEY_WORD_0:   key_word_q[0]  <= pwdata[KeyWordW-1:0];
        REG_KEY_WORD_1:   key_word_q[1]  <= pwdata[KeyWordW-1:0];
        REG_KEY_WORD_2:   key_word_q[2]  <= pwdata[KeyWordW-1:0];
        REG_KEY_WORD_3:   key_word_q[3]  <= pwdata[KeyWordW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_KEY_LENGTH:   prdata = DataW'(key_length_q);
      REG_DECRYPT_MODE: prdata = DataW'(decrypt_mode_q);
      REG_KEY_WORD_0:   prdata = DataW'(key_word_q[0]);
      REG_KEY_WORD_1:   prdata = DataW'(key_word_q[1]);
      REG_KEY_WORD_2:   prdata = DataW'(key_word_q[2]);
      REG_KEY_WORD_3:   prdata = DataW'(key_word_q[3]);
      default:          prdata = '0;
    endcase
  end

  assign cfg_o.key_length   = key_length_q;
  assign cfg_o.decrypt_mode = decrypt_mode_q;
  assign cfg_o.key_syms     = {key_word_q[3], key_word_q[2], key_word_q[1], key_word_q[0]};

endmodule

`default_nettype wire

[sv/vc40_front.sv]
// ----------------------------------------------------------------------------
// vc40_front
// Input register and key position counter; picks the key symbol for each
// accepted request.
// ----------------------------------------------------------------------------
`default_nettype none

module vc40_front import vc40_pkg::*; #(
  parameter int unsigned KEY_MAX = KeyMaxDefault,
  localparam int unsigned PosW   = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire cfg_t            cfg_i,
  input  wire logic            in_valid_i,
  input  wire in_req_t         in_req_i,
  output logic                 in_stall_o,
  input  wire logic            back_ready_i,
  output logic                 stage_valid_o,
  output stage_t               stage_o,
  output logic      [PosW-1:0] key_pos_o
);

  logic              stage_valid_q, stage_valid_d;
  stage_t            stage_q;
  logic [PosW-1:0]   pos_q, pos_d;
  logic              load;
  logic [LenW-1:0]   len_eff;
  logic [PosW:0]     pos_inc;
  logic [KeyIdxW-1:0] key_idx;
  logic [SymW-1:0]   key_raw, key_sym;

  assign in_stall_o = stage_valid_q & ~back_ready_i;
  assign load       = in_valid_i & ~in_stall_o;

  always_comb begin
    if (cfg_i.key_length == '0) begin
      len_eff = LenW'(1);
    end else if (cfg_i.key_length > LenW'(KEY_MAX)) begin
      len_eff = LenW'(KEY_MAX);
    end else begin
      len_eff = cfg_i.key_length;
    end
  end

  assign key_idx = KeyIdxW'(pos_q);
  assign key_raw = cfg_i.key_syms[key_idx * SymW +: SymW];
  assign key_sym = ({1'b0, key_raw} >= SymCount) ? SymW'({1'b0, key_raw} - SymCount)
                                                 : key_raw;
  assign pos_inc = {1'b0, pos_q} + (PosW+1)'(1);

  always_comb begin
    pos_d         = pos_q;
    stage_valid_d = stage_valid_q & ~back_ready_i;
    if (load) begin
      stage_valid_d = 1'b1;
      if (in_req_i.message_end || LenW'(pos_inc) >= len_eff) begin
        pos_d = '0;
      end else begin
        pos_d = PosW'(pos_inc);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
      pos_q         <= '0;
    end else begin
      stage_valid_q <= stage_valid_d;
      pos_q         <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      stage_q.text_byte   <= in_req_i.text_byte;
      stage_q.message_end <= in_req_i.message_end;
      stage_q.key_sym     <= key_sym;
    end
  end

  assign stage_valid_o = stage_valid_q;
  assign stage_o       = stage_q;
  assign key_pos_o     = pos_q;

endmodule

`default_nettype wire

[sv/vc40_back.sv]
// ----------------------------------------------------------------------------
// vc40_back
// Symbol mapping, modulo-40 shift and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module vc40_back import vc40_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   decrypt_mode_i,
  input  wire logic   stage_valid_i,
  input  wire stage_t stage_i,
  output logic        back_ready_o,
  output logic        out_valid_o,
  output out_req_t    out_req_o,
  input  wire logic   out_stall_i
);

  logic            out_valid_q;
  out_req_t        out_req_q;
  logic            load;
  logic [SymW-1:0] sym_in, sym_out;

  assign back_ready_o = ~out_valid_q | ~out_stall_i;
  assign load         = stage_valid_i & back_ready_o;

  assign sym_in  = byte_to_symbol(stage_i.text_byte);
  assign sym_out = mod_shift(sym_in, stage_i.key_sym, decrypt_mode_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= load | (out_valid_q & out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_req_q.cipher_byte    <= symbol_to_byte(sym_out);
      out_req_q.end_of_message <= stage_i.message_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;

endmodule

`default_nettype wire

[sv/vigenere_40_symbol_cipher_core.sv]
// ----------------------------------------------------------------------------
// vigenere_40_symbol_cipher_core
// Vigenere stream cipher over a 40-symbol alphabet, one text byte per request.
// ----------------------------------------------------------------------------
// The core takes one request per clock while the output is not stalled and
// delivers one result per request. The rate is set by the two-register
// pipeline: the input register, which also latches the key symbol at the
// current key position, and the result register behind the mapping and
// modulo-40 shift logic. The key position advances on each accepted
// request, wraps at the key length and restarts after a request marked as the
// end of a message. Registers sit on an APB port at 8-byte spacing: key length,
// decrypt mode, then the four key words of eight 6-bit symbols each. Write
// registers only while the core is empty.
`default_nettype none

module vigenere_40_symbol_cipher_core import vc40_pkg::*; #(
  parameter int unsigned KEY_MAX = KeyMaxDefault
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready,
  input  wire logic             in_valid_i,
  input  wire in_req_t          in_req_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  output out_req_t              out_req_o,
  input  wire logic             out_stall_i
);

  localparam int unsigned PosW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;

  cfg_t            cfg;
  logic            stage_valid;
  stage_t          stage;
  logic            back_ready;
  logic [PosW-1:0] key_pos;

  vc40_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  vc40_front #(
    .KEY_MAX (KEY_MAX)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (in_valid_i),
    .in_req_i      (in_req_i),
    .in_stall_o    (in_stall_o),
    .back_ready_i  (back_ready),
    .stage_valid_o (stage_valid),
    .stage_o       (stage),
    .key_pos_o     (key_pos)
  );

  vc40_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .decrypt_mode_i (cfg.decrypt_mode),
    .stage_valid_i  (stage_valid),
    .stage_i        (stage),
    .back_ready_o   (back_ready),
    .out_valid_o    (out_valid_o),
    .out_req_o      (out_req_o),
    .out_stall_i    (out_stall_i)
  );

  a_pos_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_req_i.message_end) |=> (key_pos == '0))
    else $error("key position did not restart after end of message");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, key_pos} < (PosW+1)'(KEY_MAX)) || (KEY_MAX == 1 && key_pos == '0))
    else $error("key position beyond key capacity");

  a_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stage_valid && back_ready) |=> out_valid_o)
    else $error("staged request lost before result register");

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> stage_valid)
    else $error("accepted request not held in input register");

endmodule

`default_nettype wire

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 40-symbol Vigenere cipher core. A scoreboard
// predicts each result from its own copy of the key registers and the key
// position, and compares it field by field with the core's output. Directed
// requests cover the alphabet edges and register corner cases; random message
// streams then run under several key settings and idle/stall mixes.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import vc40_pkg::*;

  localparam int unsigned Alphabet     = 40;
  localparam int unsigned WatchdogMax  = 2000;
  localparam int unsigned PhaseItems   = 135;
  localparam int unsigned PrintMax     = 200;
  localparam logic [RegIdxW-1:0] RegSpareLow  = 3'd6;
  localparam logic [RegIdxW-1:0] RegSpareHigh = 3'd7;

  class cipher_scoreboard;
    logic [LenW-1:0]     key_len;
    logic                decrypt;
    logic [KeyWordW-1:0] key_word [KeyWords];
    logic [KeyIdxW-1:0]  key_pos;
    out_req_t            pending [$];
    int unsigned         errors;

    function new();
      key_len = LenW'(1);
      decrypt = 1'b0;
      foreach (key_word[i]) key_word[i] = '0;
      key_pos = '0;
      errors  = 0;
    endfunction

    function logic [SymW-1:0] symbol_of(logic [7:0] b);
      if (b inside {[8'd97:8'd122]}) return SymW'(b - 8'd97);
      if (b inside {[8'd48:8'd57]}) return SymW'(b - 8'd18);
      case (b)
        8'd32:   return 6'd26;
        8'd46:   return 6'd27;
        8'd44:   return 6'd28;
        8'd39:   return 6'd29;
        default: return 6'd0;
      endcase
    endfunction

    function logic [7:0] byte_of(logic [SymW-1:0] s);
      if (s < 6'd26) return 8'd97 + 8'(s);
      case (s)
        6'd26:   return 8'd32;
        6'd27:   return 8'd46;
        6'd28:   return 8'd44;
        6'd29:   return 8'd39;
        default: return (s < 6'd40) ? 8'(s) + 8'd18 : 8'd97;
      endcase
    endfunction

    function void write_reg(logic [RegIdxW-1:0] idx, logic [DataW-1:0] value);
      case (idx)
        REG_KEY_LENGTH:   key_len     = value[LenW-1:0];
        REG_DECRYPT_MODE: decrypt     = value[0];
        REG_KEY_WORD_0:   key_word[0] = value[KeyWordW-1:0];
        REG_KEY_WORD_1:   key_word[1] = value[KeyWordW-1:0];
        REG_KEY_WORD_2:   key_word[2] = value[KeyWordW-1:0];
        REG_KEY_WORD_3:   key_word[3] = value[KeyWordW-1:0];
        default: ;
      endcase
    endfunction

    function void note_request(in_req_t req);
      logic [SymW-1:0] sym;
      logic [SymW-1:0] key;
      int unsigned     len;
      int unsigned     shifted;
      out_req_t        want;
      sym = symbol_of(req.text_byte);
      key = key_word[key_pos[4:3]][SymW*key_pos[2:0] +: SymW];
      if (key >= Alphabet) key = SymW'(key - Alphabet);
      len = (key_len == 0) ? 1 : ((key_len > KeyMaxDefault) ? KeyMaxDefault : key_len);
      if (decrypt) shifted = (sym + Alphabet - key) % Alphabet;
      else shifted = (sym + key) % Alphabet;
      want.cipher_byte    = byte_of(SymW'(shifted));
      want.end_of_message = req.message_end;
      pending.push_back(want);
      if (req.message_end || key_pos + 1 >= len) key_pos = '0;
      else key_pos = key_pos + 1'b1;
    endfunction

    task report(string msg);
      if (errors < PrintMax) $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(out_req_t got);
      out_req_t want;
      if (pending.size() == 0) begin
        report($sformatf("result %h with nothing expected", got));
        return;
      end
      want = pending.pop_front();
      if (got.cipher_byte !== want.cipher_byte) begin
        report($sformatf("cipher_byte %h, expected %h", got.cipher_byte, want.cipher_byte));
      end
      if (got.end_of_message !== want.end_of_message) begin
        report($sformatf("end_of_message %b, expected %b", got.end_of_message,
                         want.end_of_message));
      end
    endtask
  endclass

  logic             clk_i   = 1'b0;
  logic             rst_ni  = 1'b0;
  logic             psel    = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite  = 1'b0;
  logic [AddrW-1:0] paddr   = '0;
  logic [DataW-1:0] pwdata  = '0;
  logic [DataW-1:0] prdata;
  logic             pready;
  logic             in_valid_i  = 1'b0;
  in_req_t          in_req_i    = '0;
  logic             in_stall_o;
  logic             out_valid_o;
  out_req_t         out_req_o;
  logic             out_stall_i = 1'b0;

  cipher_scoreboard sb;
  int unsigned      in_idle_pct   = 0;
  int unsigned      out_stall_pct = 0;
  int unsigned      quiet_cycles  = 0;

  vigenere_40_symbol_cipher_core uut (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .in_valid_i,
    .in_req_i,
    .in_stall_o,
    .out_valid_o,
    .out_req_o,
    .out_stall_i
  );

  always #6 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_stall_i = rst_ni && ($urandom_range(99) < out_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_req_o);
    if (!rst_ni || psel || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogMax) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  function automatic void set_idling(int unsigned mode);
    case (mode)
      0:       begin in_idle_pct = 0;  out_stall_pct = 0;  end
      1:       begin in_idle_pct = 66; out_stall_pct = 0;  end
      2:       begin in_idle_pct = 0;  out_stall_pct = 66; end
      default: begin in_idle_pct = 15; out_stall_pct = 15; end
    endcase
  endfunction

  function automatic logic [7:0] random_text();
    if ($urandom_range(99) < 85) return sb.byte_of(SymW'($urandom_range(Alphabet - 1)));
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [KeyWordW-1:0] random_key_word();
    logic [KeyWordW-1:0] w;
    for (int i = 0; i < KeyWordSyms; i++) begin
      if ($urandom_range(99) < 80) w[SymW*i +: SymW] = SymW'($urandom_range(Alphabet - 1));
      else w[SymW*i +: SymW] = SymW'($urandom_range(63, Alphabet));
    end
    return w;
  endfunction

  task automatic cfg_write(logic [RegIdxW-1:0] idx, logic [DataW-1:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = AddrW'(idx) << RegIdxLsb;
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_reg(idx, value);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic send_request(logic [7:0] text, logic last);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i            = 1'b1;
    in_req_i.text_byte    = text;
    in_req_i.message_end  = last;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(in_req_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    logic [7:0]  edge_bytes [12];
    int unsigned key_len;
    int unsigned sent;
    int unsigned msg_len;
    edge_bytes = '{8'h00, 8'hff, 8'd97, 8'd122, 8'd48, 8'd57,
                   8'd32, 8'd46, 8'd44, 8'd39, 8'd65, 8'h80};
    sb = new();
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    set_idling(0);

    foreach (edge_bytes[i]) send_request(edge_bytes[i], i == 11);
    drain();
    cfg_write(REG_KEY_LENGTH, KeyMaxDefault);
    cfg_write(REG_DECRYPT_MODE, 0);
    cfg_write(REG_KEY_WORD_0, {KeyWordW{1'b1}});
    cfg_write(REG_KEY_WORD_1, random_key_word());
    cfg_write(REG_KEY_WORD_2, random_key_word());
    cfg_write(REG_KEY_WORD_3, random_key_word());
    for (int i = 0; i < 6; i++) send_request(random_text(), 1'b0);
    drain();
    cfg_write(REG_KEY_LENGTH, 2);
    cfg_write(REG_DECRYPT_MODE, 1);
    for (int i = 0; i < 4; i++) send_request(random_text(), i == 3);
    drain();
    cfg_write(REG_KEY_LENGTH, 0);
    cfg_write(RegSpareLow, '1);
    cfg_write(RegSpareHigh, {$urandom, $urandom});
    for (int i = 0; i < 3; i++) send_request(random_text(), 1'b0);

    for (int p = 0; p < 12; p++) begin
      drain();
      set_idling(p % 4);
      case (p)
        0:       key_len = 1;
        1:       key_len = KeyMaxDefault;
        2:       key_len = 0;
        3:       key_len = 63;
        4:       key_len = KeyMaxDefault + 1;
        default: key_len = $urandom_range(KeyMaxDefault, 1);
      endcase
      cfg_write(REG_KEY_LENGTH, key_len);
      cfg_write(REG_DECRYPT_MODE, (p / 2) % 2);
      if (p % 3 != 2) begin
        cfg_write(REG_KEY_WORD_0, (p == 5) ? {$urandom, $urandom} : random_key_word());
        cfg_write(REG_KEY_WORD_1, (p == 5) ? {$urandom, $urandom} : random_key_word());
        cfg_write(REG_KEY_WORD_2, (p == 5) ? {$urandom, $urandom} : random_key_word());
        cfg_write(REG_KEY_WORD_3, (p == 5) ? {$urandom, $urandom} : random_key_word());
      end
      sent = 0;
      while (sent < PhaseItems) begin
        msg_len = $urandom_range(40, 1);
        for (int j = 0; j < msg_len && sent < PhaseItems; j++) begin
          send_request(random_text(), j == msg_len - 1);
          sent++;
          if (p % 3 == 1 && sent == PhaseItems / 2) drain();
        end
      end
    end

    drain();
    repeat (10) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
